[rtl/bcdsd_pkg.sv]
package bcdsd_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned BATT_W = 7;
    localparam int unsigned SCAN_W = 4;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned FRAME_DEPTH = 8;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [SCAN_W-1:0] SCAN_LAST = 4'd8;
    localparam logic [BATT_W-1:0] BATT_MAX = 7'd99;
    localparam logic [7:0] SEG_POINT = 8'h10;
    localparam logic [7:0] SEG_MINUS = 8'h40;
    localparam logic [7:0] SEG_BLANK = 8'h00;
    localparam logic [7:0] COLUMN_NONE = 8'hFF;

    // floor(v / 10) == (v * 205) >> 11 for every v up to 1028.
    localparam logic [7:0] RECIP_TEN = 8'd205;
    localparam int unsigned RECIP_SHIFT = 11;

    typedef struct packed {
        logic [VALUE_W-1:0] magnitude;
        logic               negative;
        logic               freeze;
        logic [DIGIT_W-1:0] batt_tens;
        logic [DIGIT_W-1:0] batt_ones;
        logic [SCAN_W-1:0]  scan_count;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CONV,
        BK_DRAW
    } t_back_state;

    function automatic logic [7:0] time_glyph(input logic [DIGIT_W-1:0] digit);
        logic [7:0] glyph;
        unique case (digit)
            4'd0:    glyph = 8'hAF;
            4'd1:    glyph = 8'h06;
            4'd2:    glyph = 8'hCB;
            4'd3:    glyph = 8'hC7;
            4'd4:    glyph = 8'h66;
            4'd5:    glyph = 8'hE5;
            4'd6:    glyph = 8'hED;
            4'd7:    glyph = 8'h07;
            4'd8:    glyph = 8'hEF;
            4'd9:    glyph = 8'hE7;
            default: glyph = SEG_BLANK;
        endcase
        return glyph;
    endfunction

    function automatic logic [7:0] batt_glyph(input logic [DIGIT_W-1:0] digit);
        logic [7:0] glyph;
        unique case (digit)
            4'd0:    glyph = 8'h3F;
            4'd1:    glyph = 8'h06;
            4'd2:    glyph = 8'h5B;
            4'd3:    glyph = 8'h4F;
            4'd4:    glyph = 8'h66;
            4'd5:    glyph = 8'h6D;
            4'd6:    glyph = 8'h7D;
            4'd7:    glyph = 8'h07;
            4'd8:    glyph = 8'h7F;
            4'd9:    glyph = 8'h67;
            default: glyph = SEG_BLANK;
        endcase
        return glyph;
    endfunction

endpackage

[rtl/bcdsd_if.sv]
interface bcdsd_in_if;
    import bcdsd_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [VALUE_W-1:0]        elapsed_time;
    logic signed [VALUE_W-1:0] signed_delta;
    logic [BATT_W-1:0]         battery_percent;
    logic                      freeze;
    modport source(output valid, elapsed_time, signed_delta, battery_percent, freeze,
                   input ready);
    modport sink(input valid, elapsed_time, signed_delta, battery_percent, freeze,
                 output ready);
endinterface

interface bcdsd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] column_select;
    logic [8:0] segment_pins;
    logic       drive_valid;
    modport source(output valid, column_select, segment_pins, drive_valid, input ready);
    modport sink(input valid, column_select, segment_pins, drive_valid, output ready);
endinterface

interface bcdsd_cfg_if;
    logic valid;
    logic ready;
    logic display_mode;
    modport source(output valid, display_mode, input ready);
    modport sink(input valid, display_mode, output ready);
endinterface

[rtl/bcdsd_front.sv]
module bcdsd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bcdsd_in_if.sink         i_in,
    bcdsd_cfg_if.sink        i_cfg,
    input  logic             i_queue_full,
    output logic             o_push,
    output bcdsd_pkg::t_cmd  o_cmd
);
    import bcdsd_pkg::*;

    logic              r_mode;
    logic              n_mode;
    logic [SCAN_W-1:0] r_normal_cnt;
    logic [SCAN_W-1:0] n_normal_cnt;
    logic [SCAN_W-1:0] r_delta_cnt;
    logic [SCAN_W-1:0] n_delta_cnt;

    logic               w_accept;
    logic [SCAN_W-1:0]  w_count;
    logic [SCAN_W-1:0]  w_count_next;
    logic [VALUE_W-1:0] w_delta_bits;
    logic               w_negative;
    logic [BATT_W-1:0]  w_pct;
    logic [14:0]        w_prod;
    logic [DIGIT_W-1:0] w_tens;
    logic [BATT_W-1:0]  w_tens_x10;
    logic [BATT_W-1:0]  w_ones;

    assign i_in.ready  = !i_queue_full;
    assign i_cfg.ready = 1'b1;
    assign w_accept    = i_in.valid && !i_queue_full;
    assign o_push      = w_accept;

    assign w_count      = r_mode ? r_delta_cnt : r_normal_cnt;
    assign w_count_next = (w_count >= SCAN_LAST) ? '0 : w_count + 4'd1;

    always_comb begin
        n_mode       = r_mode;
        n_normal_cnt = r_normal_cnt;
        n_delta_cnt  = r_delta_cnt;
        if (i_cfg.valid) begin
            n_mode = i_cfg.display_mode;
        end
        if (w_accept) begin
            if (r_mode) begin
                n_delta_cnt = w_count_next;
            end else begin
                n_normal_cnt = w_count_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= 1'b0;
            r_normal_cnt <= '0;
            r_delta_cnt  <= '0;
        end else begin
            r_mode       <= n_mode;
            r_normal_cnt <= n_normal_cnt;
            r_delta_cnt  <= n_delta_cnt;
        end
    end

    // Classification: pick the shown value, split the battery into two digits.
    assign w_delta_bits = i_in.signed_delta;
    assign w_negative   = r_mode && w_delta_bits[VALUE_W-1];
    assign w_pct        = (i_in.battery_percent > BATT_MAX) ? BATT_MAX : i_in.battery_percent;
    assign w_prod       = {8'd0, w_pct} * {7'd0, RECIP_TEN};
    assign w_tens       = w_prod[RECIP_SHIFT +: DIGIT_W];
    assign w_tens_x10   = {w_tens, 3'b000} + {2'b00, w_tens, 1'b0};
    assign w_ones       = w_pct - w_tens_x10;

    always_comb begin
        o_cmd.magnitude  = !r_mode ? i_in.elapsed_time
                         : (w_negative ? (~w_delta_bits + 32'd1) : w_delta_bits);
        o_cmd.negative   = w_negative;
        o_cmd.freeze     = i_in.freeze;
        o_cmd.batt_tens  = w_tens;
        o_cmd.batt_ones  = w_ones[DIGIT_W-1:0];
        o_cmd.scan_count = w_count;
    end

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_normal_cnt <= SCAN_LAST && r_delta_cnt <= SCAN_LAST)
        else $error("scan counter left its range");

endmodule

[rtl/bcdsd_queue.sv]
module bcdsd_queue #(
    parameter int unsigned DEPTH = bcdsd_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bcdsd_pkg::t_cmd i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output bcdsd_pkg::t_cmd o_cmd
);
    import bcdsd_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    t_cmd             r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue read while empty");

endmodule

[rtl/bcdsd_back.sv]
module bcdsd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  bcdsd_pkg::t_cmd i_cmd,
    output logic            o_pop,
    bcdsd_out_if.source     o_out
);
    import bcdsd_pkg::*;

    localparam int unsigned STEP_W = $clog2(VALUE_W);
    localparam int unsigned NDIGIT = VALUE_W / DIGIT_W;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(VALUE_W - 1);

    t_back_state        r_state;
    t_back_state        n_state;
    t_cmd               r_cmd;
    logic [VALUE_W-1:0] r_acc;
    logic [VALUE_W-1:0] r_bin;
    logic [STEP_W-1:0]  r_step;
    logic [7:0]         r_frame [FRAME_DEPTH];

    logic       r_out_valid;
    logic [7:0] r_col;
    logic [8:0] r_seg;
    logic       r_drive;

    logic               w_start;
    logic               w_step_en;
    logic               w_draw;
    logic               w_out_free;
    logic [VALUE_W-1:0] w_adjusted;
    logic [7:0]         w_frame [FRAME_DEPTH];
    logic [7:0]         w_byte;

    assign w_out_free = !r_out_valid || o_out.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    n_state = i_cmd.freeze ? BK_DRAW : BK_CONV;
                end
            end
            BK_CONV: begin
                if (r_step == STEP_LAST) begin
                    n_state = BK_DRAW;
                end
            end
            BK_DRAW: begin
                if (w_out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        w_start   = 1'b0;
        w_step_en = 1'b0;
        w_draw    = 1'b0;
        unique case (r_state)
            BK_IDLE: w_start   = !i_empty;
            BK_CONV: w_step_en = 1'b1;
            BK_DRAW: w_draw    = w_out_free;
            default: ;
        endcase
    end

    assign o_pop = w_start;

    // One double dabble step: add three to every digit of five or more.
    always_comb begin
        for (int d = 0; d < NDIGIT; d++) begin
            w_adjusted[d*DIGIT_W +: DIGIT_W] = (r_acc[d*DIGIT_W +: DIGIT_W] >= 4'd5)
                ? r_acc[d*DIGIT_W +: DIGIT_W] + 4'd3
                : r_acc[d*DIGIT_W +: DIGIT_W];
        end
    end

    // Frame after this item: time digits unless frozen, battery every time.
    always_comb begin
        for (int i = 0; i < FRAME_DEPTH; i++) begin
            w_frame[i] = r_frame[i];
        end
        if (!r_cmd.freeze) begin
            w_frame[6] = r_cmd.negative ? SEG_MINUS : time_glyph(r_acc[23:20]);
            w_frame[5] = time_glyph(r_acc[19:16]);
            w_frame[4] = SEG_BLANK;
            w_frame[3] = time_glyph(r_acc[15:12]) | SEG_POINT;
            w_frame[2] = time_glyph(r_acc[11:8]);
        end
        w_frame[1] = batt_glyph(r_cmd.batt_tens);
        w_frame[0] = batt_glyph(r_cmd.batt_ones);
    end

    assign w_byte = w_frame[r_cmd.scan_count[2:0]];

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_cmd  <= i_cmd;
            r_acc  <= '0;
            r_bin  <= i_cmd.magnitude;
            r_step <= '0;
        end else if (w_step_en) begin
            r_acc  <= {w_adjusted[VALUE_W-2:0], r_bin[VALUE_W-1]};
            r_bin  <= {r_bin[VALUE_W-2:0], 1'b0};
            r_step <= r_step + 1'b1;
        end
        if (w_draw) begin
            if (r_cmd.scan_count < SCAN_LAST) begin
                r_col <= ~(8'd1 << r_cmd.scan_count[2:0]);
                r_seg <= {w_byte[7:2], 1'b0, w_byte[1:0]};
            end else begin
                r_col <= COLUMN_NONE;
                r_seg <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
            r_drive     <= 1'b0;
            for (int i = 0; i < FRAME_DEPTH; i++) begin
                r_frame[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_draw) begin
                r_out_valid <= 1'b1;
                r_drive     <= (r_cmd.scan_count < SCAN_LAST);
                for (int i = 0; i < FRAME_DEPTH; i++) begin
                    r_frame[i] <= w_frame[i];
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.column_select = r_col;
    assign o_out.segment_pins  = r_seg;
    assign o_out.drive_valid   = r_drive;

    a_one_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_drive) |-> $onehot(~r_col))
        else $error("driven slot does not select exactly one column");

    a_idle_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_drive) |-> (r_col == COLUMN_NONE && r_seg == '0))
        else $error("idle slot drives a column or segment");

    a_frame_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame[4] == SEG_BLANK && r_frame[7] == SEG_BLANK)
        else $error("blank frame position was lit");

endmodule

[rtl/bcd_seven_segment_scan_display.sv]
// Scan display for a lap timer: every transfer on i_in is one scan tick and yields
// exactly one transfer on o_out, the column and segment drive for that tick. Unless
// the tick is frozen, the shown value (elapsed time, or the delta magnitude with a
// minus sign in delta mode) is converted to BCD by double dabble, one bit per cycle:
// the back end takes the item from the queue, runs 32 conversion steps and then draws
// the frame once its result register is free; a frozen tick skips the conversion.
// The front end accepts ticks into a QUEUE_DEPTH entry queue while the back end
// works, and the result register lets the next conversion run while a result waits.
// display_mode may be written at any time the block idles.
module bcd_seven_segment_scan_display #(
    parameter int unsigned QUEUE_DEPTH = bcdsd_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bcdsd_in_if.sink     i_in,
    bcdsd_cfg_if.sink    i_cfg,
    bcdsd_out_if.source  o_out
);
    import bcdsd_pkg::*;

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_empty;
    t_cmd w_front_cmd;
    t_cmd w_back_cmd;

    bcdsd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg        (i_cfg),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_cmd        (w_front_cmd)
    );

    bcdsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_cmd   (w_back_cmd)
    );

    bcdsd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_cmd   (w_back_cmd),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

[tb/scan_display_checker.sv]
module scan_display_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    bcdsd_in_if   i_tick,
    bcdsd_cfg_if  i_cfg,
    bcdsd_out_if  i_drive,
    output int    o_fail_count,
    output int    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import bcdsd_pkg::*;

    localparam int unsigned REPORT_LIMIT = 10;

    localparam logic [7:0] TIME_SEGS [16] = '{
        8'hAF, 8'h06, 8'hCB, 8'hC7, 8'h66, 8'hE5, 8'hED, 8'h07,
        8'hEF, 8'hE7, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };
    localparam logic [7:0] BATT_SEGS [16] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
        8'h7F, 8'h67, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    typedef struct packed {
        logic [7:0] column;
        logic [8:0] segs;
        logic       drive;
    } t_drive;

    logic [7:0]        scan_frame [8];
    logic [SCAN_W-1:0] normal_slot;
    logic [SCAN_W-1:0] delta_slot;
    logic              delta_mode;
    t_drive            expected_drive [$];
    int                fail_count = 0;

    function automatic logic [31:0] double_dabble(input logic [31:0] bin);
        logic [31:0] acc;
        logic [31:0] shreg;
        acc = '0;
        shreg = bin;
        for (int step = 0; step < 32; step++) begin
            for (int d = 0; d < 8; d++) begin
                if (acc[4*d +: 4] >= 4'd5) begin
                    acc[4*d +: 4] = acc[4*d +: 4] + 4'd3;
                end
            end
            acc = {acc[30:0], shreg[31]};
            shreg = shreg << 1;
        end
        return acc;
    endfunction

    // Updates the frame and the active scan counter, and returns this tick's drive.
    function automatic t_drive scan_tick(input logic [31:0] elapsed, input logic [31:0] delta,
                                         input logic [6:0] batt, input logic frozen);
        logic [31:0]       shown;
        logic [31:0]       bcd;
        logic              minus;
        int unsigned       pct;
        logic [SCAN_W-1:0] slot;
        logic [7:0]        b;
        t_drive            r;
        if (!frozen) begin
            minus = delta_mode && delta[31];
            if (!delta_mode) begin
                shown = elapsed;
            end else if (minus) begin
                shown = 32'd0 - delta;
            end else begin
                shown = delta;
            end
            bcd = double_dabble(shown);
            scan_frame[6] = minus ? SEG_MINUS : TIME_SEGS[bcd[23:20]];
            scan_frame[5] = TIME_SEGS[bcd[19:16]];
            scan_frame[4] = SEG_BLANK;
            scan_frame[3] = TIME_SEGS[bcd[15:12]] | SEG_POINT;
            scan_frame[2] = TIME_SEGS[bcd[11:8]];
        end
        pct = (batt > BATT_MAX) ? BATT_MAX : batt;
        scan_frame[1] = BATT_SEGS[pct / 10];
        scan_frame[0] = BATT_SEGS[pct % 10];

        slot = delta_mode ? delta_slot : normal_slot;
        if (slot < SCAN_LAST) begin
            b = scan_frame[slot[2:0]];
            r.column = ~(8'd1 << slot);
            r.segs = {b[7:2], 1'b0, b[1:0]};
            r.drive = 1'b1;
        end else begin
            r.column = COLUMN_NONE;
            r.segs = '0;
            r.drive = 1'b0;
        end
        slot = (slot == SCAN_LAST) ? '0 : slot + 1'b1;
        if (delta_mode) begin
            delta_slot = slot;
        end else begin
            normal_slot = slot;
        end
        return r;
    endfunction

    function automatic void note_failure(input string msg);
        if (fail_count < REPORT_LIMIT) begin
            $display("%0t ns: %s", $time, msg);
        end
        fail_count++;
    endfunction

    always @(posedge i_clk) begin
        t_drive got;
        t_drive want;
        if (!i_rst_n) begin
            foreach (scan_frame[i]) scan_frame[i] = 8'h00;
            normal_slot = '0;
            delta_slot = '0;
            delta_mode = 1'b0;
            expected_drive.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                delta_mode = i_cfg.display_mode;
            end
            // Compare before pushing: a result can never belong to a tick of the same edge.
            if (i_drive.valid && i_drive.ready) begin
                got.column = i_drive.column_select;
                got.segs = i_drive.segment_pins;
                got.drive = i_drive.drive_valid;
                if (expected_drive.size() == 0) begin
                    note_failure($sformatf("unexpected drive transfer: col=%h seg=%h drv=%b",
                                           got.column, got.segs, got.drive));
                end else begin
                    want = expected_drive.pop_front();
                    if (got.column !== want.column || got.segs !== want.segs ||
                        got.drive !== want.drive) begin
                        note_failure($sformatf(
                            {"drive mismatch: col exp %h got %h, ",
                             "seg exp %h got %h, drv exp %b got %b"},
                            want.column, got.column, want.segs, got.segs, want.drive, got.drive));
                    end
                end
            end
            if (i_tick.valid && i_tick.ready) begin
                expected_drive.push_back(scan_tick(i_tick.elapsed_time, i_tick.signed_delta,
                                                   i_tick.battery_percent, i_tick.freeze));
            end
        end
        o_fail_count <= fail_count;
        o_pending <= expected_drive.size();
    end

endmodule

[tb/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic MODE_TIME = 1'b0;
    localparam logic MODE_DELTA = 1'b1;

    localparam int TICKS_PER_SEGMENT = 250;
    localparam int LONG_HOLD = 400;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT = 600000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending_count;
    int   cycle_count;
    int   sender_idle_pct = 0;
    int   receiver_stall_pct = 0;
    int   hold_requests = 0;
    int   hold_served = 0;
    int   hold_left = 0;

    bcdsd_in_if  tick_ch ();
    bcdsd_cfg_if cfg_ch ();
    bcdsd_out_if drive_ch ();

    bcd_seven_segment_scan_display DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_ch),
        .i_cfg   (cfg_ch),
        .o_out   (drive_ch)
    );

    scan_display_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (tick_ch),
        .i_cfg        (cfg_ch),
        .i_drive      (drive_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver side: random stalls, plus a long hold-off whenever one is requested.
    initial begin
        drive_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                drive_ch.ready <= 1'b0;
            end else if (hold_served != hold_requests) begin
                hold_served++;
                hold_left = LONG_HOLD;
                drive_ch.ready <= 1'b0;
            end else begin
                drive_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_tick(input logic [31:0] elapsed, input logic [31:0] delta,
                             input logic [6:0] batt, input logic frozen);
        while ($urandom_range(99) < sender_idle_pct) begin
            tick_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.elapsed_time <= elapsed;
        tick_ch.signed_delta <= delta;
        tick_ch.battery_percent <= batt;
        tick_ch.freeze <= frozen;
        do @(posedge i_clk); while (!tick_ch.ready);
    endtask

    // The checker's pending count is registered, so look only after the last transfer settled.
    task automatic wait_drained();
        tick_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    task automatic write_mode(input logic mode);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.display_mode <= mode;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_elapsed();
        unique case ($urandom_range(9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2, 3, 4: return $urandom;
            5, 6, 7: return $urandom_range(99999999);
            8:       return $urandom_range(9999);
            default: return 32'd100000000 + $urandom_range(999999999);
        endcase
    endfunction

    function automatic logic [31:0] pick_delta();
        unique case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3, 4, 5: return $urandom;
            6, 7:    return $urandom_range(99999);
            default: return 32'd0 - $urandom_range(99999999);
        endcase
    endfunction

    task automatic send_random_tick();
        logic [6:0] batt;
        batt = ($urandom_range(99) < 85) ? 7'($urandom_range(99)) : 7'($urandom_range(127, 100));
        send_tick(pick_elapsed(), pick_delta(), batt, $urandom_range(4) == 0);
    endtask

    initial begin
        int sender_pcts [4];
        int receiver_pcts [4];
        sender_pcts = '{0, 61, 0, 6};
        receiver_pcts = '{0, 0, 61, 6};

        i_rst_n <= 1'b0;
        tick_ch.valid <= 1'b0;
        tick_ch.elapsed_time <= '0;
        tick_ch.signed_delta <= '0;
        tick_ch.battery_percent <= '0;
        tick_ch.freeze <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.display_mode <= MODE_TIME;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed ticks in time mode: digit extremes, lost high digits, battery clamp, freeze.
        write_mode(MODE_TIME);
        send_tick(32'd0, 32'd0, 7'd0, 1'b0);
        send_tick(32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd99, 1'b0);
        send_tick(32'd99999999, 32'h8000_0000, 7'd100, 1'b0);
        send_tick(32'd100000000, 32'd0, 7'd127, 1'b0);
        send_tick(32'd12345678, 32'd5, 7'd50, 1'b0);
        send_tick(32'd87654321, 32'd0, 7'd7, 1'b1);
        send_tick(32'd5, 32'h7FFF_FFFF, 7'd9, 1'b1);
        send_tick(32'd98765432, 32'd0, 7'd10, 1'b0);
        send_tick(32'd1, 32'd0, 7'd1, 1'b0);
        send_tick(32'd4000000000, 32'd0, 7'd64, 1'b0);

        // Directed ticks in delta mode: sign handling and the most negative delta.
        write_mode(MODE_DELTA);
        send_tick(32'hFFFF_FFFF, 32'd0, 7'd0, 1'b0);
        send_tick(32'd0, 32'hFFFF_FFFF, 7'd99, 1'b0);
        send_tick(32'd0, 32'h8000_0000, 7'd101, 1'b0);
        send_tick(32'd0, 32'h7FFF_FFFF, 7'd42, 1'b0);
        send_tick(32'd0, 32'd0 - 32'd12345678, 7'd3, 1'b0);
        send_tick(32'd0, 32'd12345678, 7'd88, 1'b0);
        send_tick(32'd0, 32'd0 - 32'd5, 7'd20, 1'b1);
        send_tick(32'd0, 32'd99999999, 7'd55, 1'b0);
        send_tick(32'd0, 32'd0 - 32'd100000000, 7'd99, 1'b0);
        send_tick(32'd0, 32'd1, 7'd0, 1'b0);

        for (int ph = 0; ph < 4; ph++) begin
            for (int half = 0; half < 2; half++) begin
                write_mode(half ? MODE_DELTA : MODE_TIME);
                sender_idle_pct = sender_pcts[ph];
                receiver_stall_pct = receiver_pcts[ph];
                for (int n = 0; n < TICKS_PER_SEGMENT; n++) begin
                    // With no sender gaps, a long receiver hold-off backs up into the input.
                    if (ph == 0 && half == 0 && n == 50) begin
                        hold_requests++;
                    end
                    if (ph == 1 && half == 1 && n == 120) begin
                        wait_drained();
                    end
                    send_random_tick();
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
